// File: rtl/dsm_pkg.sv
// Shared types, constants and letter decoding for the DNA site matcher.
package dsm_pkg;

  localparam int MaxSite    = 16;
  localparam int PosBits    = 20;
  localparam int WinIdxW    = $clog2(MaxSite);
  localparam int LenW       = $clog2(MaxSite + 1);
  localparam int CntW       = PosBits + 1;
  localparam int MaskW      = 4;
  localparam int PatW       = MaskW * MaxSite;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;
  localparam int NumLetters = 25;
  localparam logic [7:0] LetterBase = 8'd65;
  localparam logic [7:0] LetterLast = 8'd89;
  localparam logic [LenW-1:0] SiteLenReset = LenW'(6);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSitePattern = 2'd0,
    CfgSiteLength  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic shift;
    logic clear;
    logic active;
  } cell_ctrl_t;

  typedef struct packed {
    logic             bad;
    logic [MaskW-1:0] mask;
  } letter_t;

  // Letters A..Y; bad marks a letter outside the alphabet.
  localparam letter_t LetterTable [NumLetters] = '{
    '{1'b0, 4'd1}, '{1'b0, 4'd0}, '{1'b0, 4'd8}, '{1'b0, 4'd0}, '{1'b1, 4'd0},
    '{1'b1, 4'd0}, '{1'b0, 4'd4}, '{1'b0, 4'd0}, '{1'b1, 4'd0}, '{1'b1, 4'd0},
    '{1'b0, 4'd0}, '{1'b1, 4'd0}, '{1'b0, 4'd0}, '{1'b0, 4'd0}, '{1'b1, 4'd0},
    '{1'b1, 4'd0}, '{1'b1, 4'd0}, '{1'b0, 4'd0}, '{1'b0, 4'd0}, '{1'b0, 4'd2},
    '{1'b1, 4'd0}, '{1'b0, 4'd0}, '{1'b0, 4'd0}, '{1'b1, 4'd0}, '{1'b0, 4'd0}
  };

  function automatic letter_t decode_letter(input logic [7:0] c);
    letter_t    res;
    logic [7:0] off;
    off = c - LetterBase;
    if (c < LetterBase || c > LetterLast) begin
      res = '{1'b1, '0};
    end else begin
      res = LetterTable[off[4:0]];
    end
    return res;
  endfunction

endpackage

// File: rtl/dsm_cell.sv
// One window cell: holds a base mask, passes it on and checks it against its site mask.
module dsm_cell
  import dsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [MaskW-1:0] prev_i,
  input  logic [MaskW-1:0] site_mask_i,
  output logic [MaskW-1:0] mask_o,
  output logic             hit_o
);

  logic [MaskW-1:0] mask_d, mask_q;

  assign mask_d = ctrl_i.clear ? '0 : prev_i;
  assign hit_o  = !ctrl_i.active || (|(mask_d & site_mask_i));
  assign mask_o = mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (ctrl_i.shift) begin
      mask_q <= mask_d;
    end
  end

endmodule

// File: rtl/degenerate_dna_site_matcher_core.sv
// Top level of the degenerate DNA recognition-site matcher.
//
// Input stream: one ASCII letter per transaction in s_axis_tdata, with
// s_axis_tuser set on the first letter of a sequence to clear the window,
// the position count and the bad-sequence flag.
// Output stream: one result per input letter, in order: site start index in
// m_axis_tdata, site-found and bad-sequence flags in m_axis_tuser.
// A result is offered the cycle after its letter is taken. Throughput is
// one letter per cycle while the receiver keeps taking results, set by the
// shifting row of window cells, each comparing its mask in parallel.
// While the receiver stalls, the result register holds and a new letter is
// taken only when that register is free or being emptied in the same cycle.
// Configuration (site pattern, site length) is written through cfg_we_i
// while the stream is idle.
// Reset clears the window, the count and the flag, sets the pattern to zero
// and the site length to six, and empties the result register.
module degenerate_dna_site_matcher_core
  import dsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] base_char
  input  logic [0:0]          s_axis_tuser,  // [0] start_of_sequence
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // [19:0] site_start, [23:20] zero
  output logic [1:0]          m_axis_tuser   // [0] site_found, [1] bad_sequence
);

  logic [PatW-1:0] pattern_q;
  logic [LenW-1:0] length_q, len_eff;
  logic            accept, sos;
  letter_t         letter;

  logic [CntW-1:0]    seen_d, seen_q, cur;
  logic               err_d, err_q, overlong, enough, found;
  logic [PosBits-1:0] start;

  logic [MaskW-1:0] win [MaxSite];
  logic [MaskW-1:0] pat_nib [MaxSite];
  logic [MaxSite-1:0] hits;

  logic               out_valid_q, out_found_q, out_bad_q;
  logic [PosBits-1:0] out_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      length_q  <= SiteLenReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgSitePattern) begin
        pattern_q <= cfg_wdata_i[PatW-1:0];
      end else if (cfg_idx_i == CfgSiteLength) begin
        length_q <= cfg_wdata_i[LenW-1:0];
      end
    end
  end

  always_comb begin
    if (length_q == '0) begin
      len_eff = LenW'(1);
    end else if (length_q > LenW'(MaxSite)) begin
      len_eff = LenW'(MaxSite);
    end else begin
      len_eff = length_q;
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sos           = s_axis_tuser[0];
  assign letter        = decode_letter(s_axis_tdata);

  for (genvar k = 0; k < MaxSite; k++) begin : g_cell
    cell_ctrl_t       ctrl;
    logic [LenW-1:0]  pos;
    logic [MaskW-1:0] prev;

    assign pat_nib[k]  = pattern_q[k*MaskW +: MaskW];
    assign pos         = len_eff - LenW'(k) - LenW'(1);
    assign ctrl.shift  = accept;
    assign ctrl.clear  = (k != 0) && sos;
    assign ctrl.active = LenW'(k) < len_eff;
    if (k == 0) begin : g_head
      assign prev = letter.mask;
    end else begin : g_body
      assign prev = win[k-1];
    end

    dsm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_i      (prev),
      .site_mask_i (pat_nib[pos[WinIdxW-1:0]]),
      .mask_o      (win[k]),
      .hit_o       (hits[k])
    );
  end

  assign cur      = sos ? '0 : seen_q;
  assign overlong = cur[PosBits];
  assign seen_d   = overlong ? cur : cur + CntW'(1);
  assign enough   = (cur + CntW'(1)) >= CntW'(len_eff);
  assign found    = !overlong && enough && (&hits);
  assign start    = found ? (cur[PosBits-1:0] - PosBits'(len_eff) + PosBits'(1)) : '0;
  assign err_d    = (!sos && err_q) || letter.bad || overlong;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      err_q  <= 1'b0;
    end else if (accept) begin
      seen_q <= seen_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_found_q <= found;
      out_start_q <= start;
      out_bad_q   <= err_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(24 - PosBits)'(0), out_start_q};
  assign m_axis_tuser  = {out_bad_q, out_found_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= (CntW'(1) << PosBits))
    else $error("position count beyond saturation");

  a_sos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && sos |=> seen_q == CntW'(1))
    else $error("sequence start did not restart count");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !sos && err_q |=> err_q)
    else $error("bad-sequence flag dropped within a sequence");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_start_q == '0)
    else $error("site start nonzero without a site");
`endif

endmodule

// File: dv/tb.sv
// Self-checking testbench for the degenerate DNA site matcher: directed table, random phases.
module tb;
  import dsm_pkg::*;

  typedef struct packed {
    logic        found;
    logic [19:0] start;
    logic        bad;
  } site_result_t;

  typedef enum logic {
    StepLetter,
    StepConfig
  } step_kind_e;

  typedef struct packed {
    step_kind_e   kind;
    cfg_reg_e     reg_idx;
    logic [63:0]  reg_val;
    logic [7:0]   base;
    logic         sos;
    logic         typed_ok;
    site_result_t typed;
  } dir_step_t;

  localparam logic [3:0]      MaskA       = 4'd1;
  localparam logic [3:0]      MaskT       = 4'd2;
  localparam logic [3:0]      MaskG       = 4'd4;
  localparam logic [3:0]      MaskC       = 4'd8;
  localparam logic [CntW-1:0] SeqLimit    = CntW'(1) << PosBits;
  localparam logic [63:0]     AllBases    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]     GaattcSite  = 64'h0000_0000_0082_2114;
  localparam int              IdlePct     = 28;
  localparam int              HoldCycles  = 300;
  localparam int              StallLimit  = 2000;
  localparam int              NumPhases   = 10;
  localparam int              PhaseItems  = 185;
  localparam int              QuietPhase  = 5;
  localparam int              PressPhase  = 6;
  localparam int              NumDirected = 25;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  degenerate_dna_site_matcher_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [63:0]     cfg_pat = '0;
  logic [4:0]      cfg_len = 5'd6;
  logic [3:0]      win_q [MaxSite];
  logic [CntW-1:0] seen_q  = '0;
  logic            err_q   = 1'b0;

  site_result_t expected_sites [$];
  site_result_t rx_want;
  int           mismatch_cnt = 0;
  int           stall_cycles = 0;
  int           hold_asked   = 0;
  int           hold_served  = 0;
  int           hold_left    = 0;
  logic         idling       = 1'b1;
  string        bit_letters  = "ATGC";

  initial foreach (win_q[i]) win_q[i] = '0;

  dir_step_t directed [NumDirected] = '{
    '{StepLetter, CfgSitePattern, 64'd0,      "A",   1'b1, 1'b1, '{1'b0, 20'd0, 1'b0}},
    '{StepConfig, CfgSiteLength,  64'd1,      8'd0,  1'b0, 1'b0, '0},
    '{StepConfig, CfgSitePattern, AllBases,   8'd0,  1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "C",   1'b1, 1'b1, '{1'b1, 20'd0, 1'b0}},
    '{StepLetter, CfgSitePattern, 64'd0,      "G",   1'b0, 1'b1, '{1'b1, 20'd1, 1'b0}},
    '{StepLetter, CfgSitePattern, 64'd0,      "N",   1'b0, 1'b1, '{1'b0, 20'd0, 1'b0}},
    '{StepLetter, CfgSitePattern, 64'd0,      "E",   1'b0, 1'b1, '{1'b0, 20'd0, 1'b1}},
    '{StepLetter, CfgSitePattern, 64'd0,      "T",   1'b0, 1'b1, '{1'b1, 20'd4, 1'b1}},
    '{StepLetter, CfgSitePattern, 64'd0,      8'h00, 1'b0, 1'b1, '{1'b0, 20'd0, 1'b1}},
    '{StepLetter, CfgSitePattern, 64'd0,      8'hFF, 1'b0, 1'b1, '{1'b0, 20'd0, 1'b1}},
    '{StepLetter, CfgSitePattern, 64'd0,      "Y",   1'b1, 1'b1, '{1'b0, 20'd0, 1'b0}},
    '{StepLetter, CfgSitePattern, 64'd0,      "Z",   1'b0, 1'b1, '{1'b0, 20'd0, 1'b1}},
    '{StepConfig, CfgSiteLength,  64'd0,      8'd0,  1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "A",   1'b1, 1'b1, '{1'b1, 20'd0, 1'b0}},
    '{StepLetter, CfgSitePattern, 64'd0,      "@",   1'b0, 1'b1, '{1'b0, 20'd0, 1'b1}},
    '{StepConfig, CfgSitePattern, GaattcSite, 8'd0,  1'b0, 1'b0, '0},
    '{StepConfig, CfgSiteLength,  64'd6,      8'd0,  1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "G",   1'b1, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "A",   1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "A",   1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "T",   1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "T",   1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "C",   1'b0, 1'b1, '{1'b1, 20'd0, 1'b0}},
    '{StepLetter, CfgSitePattern, 64'd0,      "S",   1'b0, 1'b0, '0},
    '{StepLetter, CfgSitePattern, 64'd0,      "C",   1'b0, 1'b0, '0}
  };

  function automatic int site_span();
    if (cfg_len == 0) return 1;
    if (cfg_len > MaxSite) return MaxSite;
    return int'(cfg_len);
  endfunction

  function automatic site_result_t predict_site(input logic [7:0] c, input logic sos);
    site_result_t    r;
    logic [3:0]      m;
    logic            inval;
    logic [CntW-1:0] cur;
    int              span;
    r     = '0;
    m     = '0;
    inval = 1'b0;
    if (sos) begin
      foreach (win_q[i]) win_q[i] = '0;
      seen_q = '0;
      err_q  = 1'b0;
    end
    case (c)
      "A": m = MaskA;
      "T": m = MaskT;
      "G": m = MaskG;
      "C": m = MaskC;
      "B", "D", "H", "K", "M", "N", "R", "S", "V", "W", "Y": m = '0;
      default: inval = 1'b1;
    endcase
    err_q = err_q | inval;
    for (int j = MaxSite - 1; j > 0; j--) win_q[j] = win_q[j-1];
    win_q[0] = m;
    cur = seen_q;
    if (seen_q < SeqLimit) seen_q = seen_q + 1'b1;
    span = site_span();
    if (cur >= SeqLimit) begin
      err_q = 1'b1;
    end else if (int'(cur) + 1 >= span) begin
      r.found = 1'b1;
      for (int j = 0; j < span; j++) begin
        if ((win_q[span-1-j] & cfg_pat[4*j +: 4]) == 4'd0) r.found = 1'b0;
      end
      if (r.found) r.start = 20'(int'(cur) + 1 - span);
    end
    r.bad = err_q;
    return r;
  endfunction

  function automatic logic [7:0] rand_letter();
    string degen = "BDHKMNRSVWY";
    string inval = "EFIJLOPQUX@Z";
    int    r;
    r = $urandom_range(99);
    if (r < 55) return bit_letters[$urandom_range(3)];
    if (r < 75) return degen[$urandom_range(degen.len() - 1)];
    if (r < 88) return inval[$urandom_range(inval.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatch_cnt++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  task automatic push_letter(input logic [7:0] c, input logic sos,
                             input logic typed_ok = 1'b0, input site_result_t typed = '0);
    site_result_t r;
    while (idling && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= sos;
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_site(c, sos);
    expected_sites.push_back(typed_ok ? typed : r);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_sites.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CfgSitePattern) cfg_pat = val;
    else if (idx == CfgSiteLength) cfg_len = val[4:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed site instances inside sequences of random length, the rest noise.
  task automatic run_phase(input int n_items);
    int         done;
    int         seq_left;
    int         site_pos;
    int         b;
    logic       sos;
    logic [3:0] nib;
    logic [7:0] c;
    done     = 0;
    seq_left = 0;
    site_pos = -1;
    sos      = 1'b1;
    while (done < n_items) begin
      if (seq_left == 0) begin
        seq_left = $urandom_range(1, 48);
        sos      = 1'b1;
        site_pos = -1;
      end
      if (site_pos < 0 && $urandom_range(99) < 30) site_pos = 0;
      if (site_pos >= 0) begin
        nib = cfg_pat[4*site_pos +: 4];
        if (nib == 4'd0 || $urandom_range(9) == 0) begin
          c = rand_letter();
        end else begin
          do b = $urandom_range(3); while (!nib[b]);
          c = bit_letters[b];
        end
        site_pos++;
        if (site_pos >= site_span()) site_pos = -1;
      end else begin
        c = rand_letter();
      end
      push_letter(c, sos);
      sos = 1'b0;
      seq_left--;
      done++;
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_sites.size() == 0) begin
        flag_mismatch("unexpected result", {6'd0, m_axis_tuser, m_axis_tdata}, 32'd0);
      end else begin
        rx_want = expected_sites.pop_front();
        if (m_axis_tuser[0] !== rx_want.found)
          flag_mismatch("site_found", 32'(m_axis_tuser[0]), 32'(rx_want.found));
        if (m_axis_tdata[19:0] !== rx_want.start)
          flag_mismatch("site_start", 32'(m_axis_tdata[19:0]), 32'(rx_want.start));
        if (m_axis_tdata[23:20] !== 4'd0)
          flag_mismatch("tdata pad", 32'(m_axis_tdata[23:20]), 32'd0);
        if (m_axis_tuser[1] !== rx_want.bad)
          flag_mismatch("bad_sequence", 32'(m_axis_tuser[1]), 32'(rx_want.bad));
      end
    end
    if (hold_served != hold_asked) begin
      hold_served   <= hold_asked;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idling && $urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] pat;
    int          len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == StepConfig) begin
        wait_idle();
        cfg_write(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        push_letter(directed[i].base, directed[i].sos, directed[i].typed_ok, directed[i].typed);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      pat = '0;
      for (int k = 0; k < MaxSite; k++) begin
        if ($urandom_range(19) == 0) pat[4*k +: 4] = 4'd0;
        else if ($urandom_range(3) == 0) pat[4*k +: 4] = 4'hF;
        else pat[4*k +: 4] = 4'($urandom_range(1, 15));
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 16);
      case (p)
        0: begin
          pat = AllBases;
          len = MaxSite;
        end
        1: begin
          pat = {$urandom, $urandom};
          len = 31;
        end
        2: begin
          pat = '0;
          len = 1;
        end
        3: len = 0;
        default: ;
      endcase
      cfg_write(CfgSitePattern, pat);
      cfg_write(CfgSiteLength, 64'(len));
      idling = (p != QuietPhase);
      if (p == PressPhase) hold_asked++;
      run_phase(PhaseItems);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
